### src/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared constants and types for the sliding window median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int POS_BITS    = $clog2(WINDOW_MAX);

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(5);
  localparam logic [LEN_BITS-1:0] LEN_MIN   = LEN_BITS'(2);

  // What one sorted-window cell shows its neighbours
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;  // held sample
    logic                   lt;   // held sample below the sample leaving
    logic                   le;   // held sample not above the sample arriving
  } cell_link_t;

endpackage

### src/swmf_ram.sv
// ----------------------------------------------------------------------------
// swmf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell
// One slot of the sorted window: drops the leaving sample and inserts the
// arriving one by looking only at its two neighbours.
// ----------------------------------------------------------------------------
module swmf_cell (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [swmf_pkg::SAMPLE_BITS-1:0] old_i,
  input  logic signed [swmf_pkg::SAMPLE_BITS-1:0] new_i,
  input  logic                                rem_i,  // window full, oldest leaves
  input  logic                                vb_i,   // slot valid after removal
  input  swmf_pkg::cell_link_t                left_i,
  input  swmf_pkg::cell_link_t                right_i,
  output swmf_pkg::cell_link_t                link_o
);

  logic signed [swmf_pkg::SAMPLE_BITS-1:0] val_q, val_d;
  logic signed [swmf_pkg::SAMPLE_BITS-1:0] b_self, b_left;
  logic                                    lt_self, le_self;
  logic                                    le_b_self, le_b_left;
  logic                                    shift_self, shift_left;

  assign lt_self = val_q < old_i;
  assign le_self = val_q <= new_i;

  assign link_o.val = val_q;
  assign link_o.lt  = lt_self;
  assign link_o.le  = le_self;

  always_comb begin
    // window after removal: slots from the removed one on take the right value
    shift_self = rem_i && !lt_self;
    shift_left = rem_i && !left_i.lt;
    b_self     = shift_self ? $signed(right_i.val) : val_q;
    le_b_self  = vb_i && (shift_self ? right_i.le : le_self);
    b_left     = shift_left ? val_q : $signed(left_i.val);
    le_b_left  = shift_left ? le_self : left_i.le;
    // insertion: keep, take the new sample, or take the left value
    if (le_b_self) begin
      val_d = b_self;
    end else if (le_b_left) begin
      val_d = new_i;
    end else begin
      val_d = b_left;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

endmodule

### src/sliding_window_median_filter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter_unit
// Running median over the last window_length samples, kept as a sorted row
// of cells beside an arrival-order ring in RAM.
//
//   channel  | dir | fields (lsb up)        | request when
//   s_axis   | in  | tdata: sample  [15:0]  | tvalid && tready
//   m_axis   | out | tdata: median  [15:0]  | tvalid && tready
//   cfg      | in  | data: window_length[6:0] | valid && ready
//
// Per sample: accept and ring RAM read, then cell row update and ring
// write, then median slot select, then average into the output register.
// The ring RAM's registered read of the leaving sample sets the update slot.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and only the final step stalls if the result is still unread.
// Reset and a window_length write empty the window; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [swmf_pkg::SAMPLE_BITS-1:0]    s_axis_tdata_i,   // sample
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [swmf_pkg::SAMPLE_BITS-1:0]    m_axis_tdata_o,   // median
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swmf_pkg::LEN_BITS-1:0]       cfg_data_i        // window_length
);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_MED, S_SUM} state_e;

  state_e                              state_q;
  logic [swmf_pkg::LEN_BITS-1:0]       len_q, act_len;
  logic [swmf_pkg::LEN_BITS-1:0]       fill_q, fill_m, pos_inc;
  logic [swmf_pkg::POS_BITS-1:0]       pos_q, pos_d;
  logic [swmf_pkg::POS_BITS-1:0]       lo_idx, hi_idx;
  logic                                m_valid_q, rem, in_req, out_load, cfg_req;
  logic signed [swmf_pkg::SAMPLE_BITS-1:0] sample_q, old_val;
  logic [swmf_pkg::SAMPLE_BITS-1:0]    lo_sel, hi_sel, lo_q, hi_q, med_q;
  logic [swmf_pkg::SAMPLE_BITS:0]      sum;
  swmf_pkg::cell_link_t                links [swmf_pkg::WINDOW_MAX];
  swmf_pkg::cell_link_t                edge_left, edge_right;

  assign in_req   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_req  = cfg_valid_i && cfg_ready_o;
  assign out_load = (state_q == S_UPD) ? 1'b0 :
                    (state_q == S_SUM) && (!m_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  // window_length only changes between samples
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = med_q;

  // out-of-range lengths are clamped
  always_comb begin
    if (len_q < swmf_pkg::LEN_MIN) begin
      act_len = swmf_pkg::LEN_MIN;
    end else if (len_q > swmf_pkg::LEN_BITS'(swmf_pkg::WINDOW_MAX)) begin
      act_len = swmf_pkg::LEN_BITS'(swmf_pkg::WINDOW_MAX);
    end else begin
      act_len = len_q;
    end
  end

  assign rem     = (fill_q == act_len);
  assign fill_m  = rem ? fill_q - 1'b1 : fill_q;
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign pos_d   = (pos_inc >= act_len) ? '0 : pos_inc[swmf_pkg::POS_BITS-1:0];

  swmf_ram #(
    .WIDTH (swmf_pkg::SAMPLE_BITS),
    .DEPTH (swmf_pkg::WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPD),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .re_i    (in_req),
    .raddr_i (pos_q),
    .rdata_o (old_val)
  );

  // row ends: nothing to the left sorts above the new sample
  assign edge_left  = '{val: '0, lt: 1'b1, le: 1'b1};
  assign edge_right = '{val: '0, lt: 1'b0, le: 1'b0};

  for (genvar j = 0; j < swmf_pkg::WINDOW_MAX; j++) begin : g_cell
    swmf_pkg::cell_link_t left_l, right_l;
    if (j == 0) begin : g_first
      assign left_l = edge_left;
    end else begin : g_mid_l
      assign left_l = links[j-1];
    end
    if (j == swmf_pkg::WINDOW_MAX - 1) begin : g_last
      assign right_l = edge_right;
    end else begin : g_mid_r
      assign right_l = links[j+1];
    end
    swmf_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (state_q == S_UPD),
      .old_i   (old_val),
      .new_i   (sample_q),
      .rem_i   (rem),
      .vb_i    (swmf_pkg::LEN_BITS'(j) < fill_m),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (links[j])
    );
  end

  // middle slots of the window
  assign lo_idx = swmf_pkg::POS_BITS'((fill_q - 1'b1) >> 1);
  assign hi_idx = swmf_pkg::POS_BITS'(fill_q >> 1);

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int j = 0; j < swmf_pkg::WINDOW_MAX; j++) begin
      lo_sel = lo_sel |
               (links[j].val & {swmf_pkg::SAMPLE_BITS{lo_idx == swmf_pkg::POS_BITS'(j)}});
      hi_sel = hi_sel |
               (links[j].val & {swmf_pkg::SAMPLE_BITS{hi_idx == swmf_pkg::POS_BITS'(j)}});
    end
  end

  // floor of the mean; equal slots when the count is odd
  assign sum = {lo_q[swmf_pkg::SAMPLE_BITS-1], lo_q} + {hi_q[swmf_pkg::SAMPLE_BITS-1], hi_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= swmf_pkg::LEN_RESET;
      fill_q    <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      med_q     <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
        med_q     <= sum[swmf_pkg::SAMPLE_BITS:1];
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_req) begin
        len_q  <= cfg_data_i;
        fill_q <= '0;
        pos_q  <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_req) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          fill_q  <= fill_m + 1'b1;
          pos_q   <= pos_d;
          state_q <= S_MED;
        end
        S_MED: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      sample_q <= s_axis_tdata_i;
    end
    if (state_q == S_MED) begin
      lo_q <= lo_sel;
      hi_q <= hi_sel;
    end
  end

`ifndef SYNTHESIS
  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= act_len)
    else $error("fill count beyond window length");

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swmf_pkg::LEN_BITS'(pos_q) < act_len)
    else $error("ring position beyond window length");

  a_req_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> state_q == S_UPD)
    else $error("accepted sample did not start an update");

  a_update_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !cfg_valid_i) |=> fill_q != '0)
    else $error("window empty after an update");
`endif

endmodule

### bench/swmf_median_checker.sv
// ----------------------------------------------------------------------------
// swmf_median_checker
// Watches the sample, median and window_length channels of the median filter.
// Keeps its own arrival ring and sorted window, predicts one median per
// accepted sample and compares every median request against the oldest
// prediction. Hands the mismatch count and the number of medians still owed
// to the testbench top.
// ----------------------------------------------------------------------------
module swmf_median_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  input  logic [swmf_pkg::SAMPLE_BITS-1:0]    s_tdata_i,    // sample
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  input  logic [swmf_pkg::SAMPLE_BITS-1:0]    m_tdata_i,    // median
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [swmf_pkg::LEN_BITS-1:0]       cfg_data_i,   // window_length
  output int                                  err_count_o,
  output int                                  pending_o
);

  localparam int SB = swmf_pkg::SAMPLE_BITS;
  localparam int WMAX = swmf_pkg::WINDOW_MAX;

  logic [swmf_pkg::LEN_BITS-1:0] win_len;
  logic [swmf_pkg::POS_BITS-1:0] ring_pos;
  logic [swmf_pkg::LEN_BITS-1:0] held;
  logic signed [SB-1:0]          arrivals [WMAX];
  logic signed [SB-1:0]          ordered  [WMAX];
  logic [SB-1:0]                 median_queue [$];
  int                            n_seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] median check: %s", $realtime, what);
    err_count_o = err_count_o + 1;
  endtask

  // 0 and 1 behave as 2, anything above the cell count as the full row
  function automatic int span_in_use();
    int len;
    len = int'(win_len);
    if (len < 2) len = 2;
    if (len > WMAX) len = WMAX;
    return len;
  endfunction

  // drops the first copy only; duplicates stay
  task automatic remove_one(input logic signed [SB-1:0] v);
    int i;
    int j;
    for (i = 0; i < int'(held); i++) begin
      if (ordered[i] == v) begin
        for (j = i; j + 1 < int'(held); j++)
          ordered[j] = ordered[j + 1];
        held = held - 1'b1;
        return;
      end
    end
  endtask

  // new sample goes after every equal one
  task automatic place_sorted(input logic signed [SB-1:0] v);
    int p;
    int j;
    if (int'(held) >= WMAX) return;
    p = 0;
    while (p < int'(held) && ordered[p] <= v) p++;
    for (j = int'(held); j > p; j--)
      ordered[j] = ordered[j - 1];
    ordered[p] = v;
    held = held + 1'b1;
  endtask

  task automatic slide_in(input logic [SB-1:0] raw, output logic [SB-1:0] med);
    int len;
    int n;
    int total;
    logic signed [SB-1:0] s;
    len = span_in_use();
    s = raw;
    if (int'(ring_pos) >= len) ring_pos = '0;
    if (int'(held) >= len) begin
      held = swmf_pkg::LEN_BITS'(len);
      remove_one(arrivals[ring_pos]);
    end
    place_sorted(s);
    arrivals[ring_pos] = s;
    if (int'(ring_pos) + 1 >= len) ring_pos = '0;
    else ring_pos = ring_pos + 1'b1;
    n = int'(held);
    if (n == 0) begin
      med = '0;
    end else if (n % 2 == 1) begin
      med = ordered[n / 2];
    end else begin
      // exact sum, floored halving
      total = int'(ordered[n / 2 - 1]) + int'(ordered[n / 2]);
      med = SB'(total >>> 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SB-1:0] want;
    if (!rst_ni) begin
      median_queue.delete();
      win_len  = swmf_pkg::LEN_RESET;
      ring_pos = '0;
      held     = '0;
      n_seen   = 0;
      err_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        win_len  = cfg_data_i;
        ring_pos = '0;
        held     = '0;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (median_queue.size() == 0) begin
          report_mismatch($sformatf("median %0d with no sample waiting",
                                    $signed(m_tdata_i)));
        end else begin
          want = median_queue.pop_front();
          if (m_tdata_i !== want)
            report_mismatch($sformatf("median #%0d got %0d want %0d", n_seen,
                                      $signed(m_tdata_i), $signed(want)));
          n_seen++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        slide_in(s_tdata_i, want);
        median_queue.push_back(want);
      end
      pending_o <= median_queue.size();
    end
  end

endmodule

### bench/sliding_window_median_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter_unit_tb
// Drives samples and window_length writes into the median filter and lets
// the checker compare every median. A directed run covers the sample
// extremes, duplicates and the floored even average; random phases then
// sweep window lengths from below to above range, with bursty idling on
// both sides, one long hold-off on the median side and a final phase at
// full rate.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_unit_tb;

  localparam int SB         = swmf_pkg::SAMPLE_BITS;
  localparam int STALL_MAX  = 3000;
  localparam int LONG_HOLD  = 400;

  logic                           clk_i;
  logic                           rst_n          = 1'b0;
  logic                           s_axis_tvalid  = 1'b0;
  logic                           s_axis_tready;
  logic [SB-1:0]                  s_axis_tdata   = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready  = 1'b0;
  logic [SB-1:0]                  m_axis_tdata;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [swmf_pkg::LEN_BITS-1:0]  cfg_data       = '0;

  logic                           idle_on        = 1'b1;
  logic                           hold_phase     = 1'b0;
  logic                           hold_done      = 1'b0;
  int                             err_count;
  int                             pending;

  sliding_window_median_filter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  swmf_median_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // median side: bursts of back-pressure, one long hold-off when asked
  initial begin
    @(posedge clk_i);
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (hold_phase && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else if (idle_on) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ends the run if no request of any kind goes through for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no request for %0d cycles, %0d medians owed", quiet, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_sample(input logic [SB-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_medians();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    // let the pipe settle before touching the register
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [swmf_pkg::LEN_BITS-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly full-range, with clusters of near-equal values for duplicates
  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return SB'($urandom);
      5, 6, 7:       return SB'(int'($urandom_range(0, 8)) - 4);
      8:             return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default:       return SB'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  task automatic run_phase(input logic [swmf_pkg::LEN_BITS-1:0] len, input int count);
    drain_medians();
    set_window(len);
    repeat (count) push_sample(pick_sample());
  endtask

  logic [SB-1:0] edge_run [] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h7FFF,
    16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000
  };
  logic [SB-1:0] pair_run [] = '{
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000,
    16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // window length left at its reset value
    foreach (edge_run[i]) push_sample(edge_run[i]);
    // length 0 acts as 2: after the first sample every median averages a pair
    drain_medians();
    set_window(7'd0);
    foreach (pair_run[i]) push_sample(pair_run[i]);

    run_phase(7'd1, 40);
    run_phase(7'd2, 50);
    run_phase(7'd3, 60);
    run_phase(7'd5, 80);
    drain_medians();
    set_window(7'd64);
    hold_phase <= 1'b1;
    repeat (220) push_sample(pick_sample());
    run_phase(7'd127, 120);
    run_phase(7'd65, 80);
    repeat (3) run_phase(swmf_pkg::LEN_BITS'($urandom_range(0, 127)), 80);

    drain_medians();
    idle_on <= 1'b0;
    set_window(swmf_pkg::LEN_BITS'($urandom_range(2, 64)));
    repeat (100) push_sample(pick_sample());

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
src/swmf_pkg.sv
src/swmf_ram.sv
src/swmf_cell.sv
src/sliding_window_median_filter_unit.sv
bench/swmf_median_checker.sv
bench/sliding_window_median_filter_unit_tb.sv
